// ===== design/tlt_pkg.sv =====
// ---------------------------------------------------------------------------
// tlt_pkg - shared types and codes for the line table block
// Input and result word layouts, item kinds, status codes and the
// character constants used by the line scanner.
// ---------------------------------------------------------------------------
package tlt_pkg;

    // item kinds on the input channel
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // result kinds
    localparam logic RK_LINE  = 1'b0;
    localparam logic RK_QUERY = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_PAST   = 2'd2;
    localparam logic [1:0] ST_CLOSED = 2'd3;

    // characters
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // field limits
    localparam logic [9:0]  LINE_MAX  = 10'd1023;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [23:0] COL_MAX   = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [23:0] query_offset;
        logic [23:0] query_length;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  status;
        logic [23:0] line_offset;
        logic [23:0] line_length;
        logic [15:0] indent_tabs;
        logic [15:0] indent_spaces;
        logic        line_blank;
        logic        has_newline;
        logic [9:0]  start_line;
        logic [23:0] start_column;
        logic [9:0]  end_line;
        logic [23:0] end_column;
    } t_out_word;

    // commands from the top level to the line scanner
    typedef struct packed {
        logic       text;
        logic       eot;
        logic [7:0] byte_value;
    } t_scan_cmd;

endpackage

// ===== design/tlt_ram.sv =====
// ---------------------------------------------------------------------------
// tlt_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module tlt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== design/tlt_scan.sv =====
// ---------------------------------------------------------------------------
// tlt_scan - line scanner
// Tracks the open line one byte a cycle, builds line records on newline
// or end of text, and writes each stored line into the line table.
// ---------------------------------------------------------------------------
module tlt_scan #(
    parameter int MAX_LINES   = 1024,
    parameter int OFFSET_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tlt_pkg::t_scan_cmd             i_cmd,
    output logic                           o_rec_valid,
    output tlt_pkg::t_out_word             o_rec,
    output logic [$clog2(MAX_LINES+1)-1:0] o_line_count,
    output logic                           o_wr_en,
    output logic [$clog2(MAX_LINES)-1:0]   o_wr_addr,
    output logic [2*OFFSET_BITS-1:0]       o_wr_data
);
    import tlt_pkg::*;

    localparam int OB  = OFFSET_BITS;
    localparam int LCW = $clog2(MAX_LINES+1);
    localparam int AW  = $clog2(MAX_LINES);
    localparam logic [OB-1:0] OFF_MAX = '1;

    logic [OB-1:0]  r_cur_off, n_cur_off;
    logic [OB-1:0]  r_cur_len, n_cur_len;
    logic [15:0]    r_tabs, n_tabs;
    logic [15:0]    r_spaces, n_spaces;
    logic           r_in_indent, n_in_indent;
    logic           r_blank, n_blank;
    logic           r_closed, n_closed;
    logic [LCW-1:0] r_line_count, n_line_count;

    logic           w_nl;
    logic [OB-1:0]  w_len_nl;
    logic [OB:0]    w_next_sum;
    logic [OB-1:0]  w_next_off;
    logic           w_room;
    logic           w_emit;
    logic           w_emit_nl;
    logic [OB-1:0]  w_emit_len;
    logic [OB+23:0] w_off_ext;
    logic [OB+23:0] w_len_ext;

    // line length with newline and the start of the next line, saturating
    always_comb begin
        w_nl       = (i_cmd.byte_value == CHAR_NL);
        w_len_nl   = (r_cur_len == OFF_MAX) ? OFF_MAX : r_cur_len + OB'(1);
        w_next_sum = {1'b0, r_cur_off} + {1'b0, w_len_nl};
        w_next_off = w_next_sum[OB] ? OFF_MAX : w_next_sum[OB-1:0];
        w_room     = (r_line_count != LCW'(MAX_LINES));
    end

    // byte and end handling
    always_comb begin
        n_cur_off    = r_cur_off;
        n_cur_len    = r_cur_len;
        n_tabs       = r_tabs;
        n_spaces     = r_spaces;
        n_in_indent  = r_in_indent;
        n_blank      = r_blank;
        n_closed     = r_closed;
        n_line_count = r_line_count;
        w_emit       = 1'b0;
        w_emit_nl    = 1'b0;
        w_emit_len   = r_cur_len;
        o_rec_valid  = 1'b0;
        o_rec        = '0;
        o_wr_en      = 1'b0;

        if (i_cmd.text) begin
            if (r_closed) begin
                o_rec_valid = 1'b1;
                o_rec.status = ST_CLOSED;
            end else if (w_nl) begin
                w_emit      = 1'b1;
                w_emit_nl   = 1'b1;
                w_emit_len  = w_len_nl;
                n_cur_off   = w_next_off;
                n_cur_len   = '0;
                n_tabs      = '0;
                n_spaces    = '0;
                n_in_indent = 1'b1;
                n_blank     = 1'b1;
            end else begin
                if (r_cur_len != OFF_MAX) begin
                    n_cur_len = r_cur_len + OB'(1);
                end
                if (r_in_indent) begin
                    if (i_cmd.byte_value == CHAR_TAB) begin
                        if (r_tabs != COUNT_MAX) n_tabs = r_tabs + 16'd1;
                    end else if (i_cmd.byte_value == CHAR_SPACE) begin
                        if (r_spaces != COUNT_MAX) n_spaces = r_spaces + 16'd1;
                    end else begin
                        n_in_indent = 1'b0;
                        n_blank     = 1'b0;
                    end
                end
            end
        end else if (i_cmd.eot && !r_closed) begin
            n_closed = 1'b1;
            if (r_cur_len != '0) begin
                w_emit = 1'b1;
            end
        end

        // line record and table write
        w_off_ext = {{24{1'b0}}, r_cur_off};
        w_len_ext = {{24{1'b0}}, w_emit_len};
        if (w_emit) begin
            o_rec_valid         = 1'b1;
            o_rec.result_kind   = RK_LINE;
            o_rec.line_offset   = w_off_ext[23:0];
            o_rec.line_length   = w_len_ext[23:0];
            o_rec.indent_tabs   = r_tabs;
            o_rec.indent_spaces = r_spaces;
            o_rec.line_blank    = r_blank;
            o_rec.has_newline   = w_emit_nl;
            if (w_room) begin
                o_wr_en      = 1'b1;
                n_line_count = r_line_count + LCW'(1);
            end else begin
                o_rec.status = ST_FULL;
            end
        end
    end

    assign o_wr_addr    = r_line_count[AW-1:0];
    assign o_wr_data    = {r_cur_off, w_emit_len};
    assign o_line_count = r_line_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_off    <= '0;
            r_cur_len    <= '0;
            r_tabs       <= '0;
            r_spaces     <= '0;
            r_in_indent  <= 1'b1;
            r_blank      <= 1'b1;
            r_closed     <= 1'b0;
            r_line_count <= '0;
        end else begin
            r_cur_off    <= n_cur_off;
            r_cur_len    <= n_cur_len;
            r_tabs       <= n_tabs;
            r_spaces     <= n_spaces;
            r_in_indent  <= n_in_indent;
            r_blank      <= n_blank;
            r_closed     <= n_closed;
            r_line_count <= n_line_count;
        end
    end

    // line count never runs past the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_count <= LCW'(MAX_LINES))
        else $error("line count beyond table depth");

    // once closed, the text stays closed
    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |=> r_closed)
        else $error("text reopened");

    // a stored line never reports a full table
    a_store_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (o_rec_valid && o_rec.status == ST_OK))
        else $error("table write without ok record");
endmodule

// ===== design/tlt_search.sv =====
// ---------------------------------------------------------------------------
// tlt_search - offset to line and column lookup
// Sequencer that binary-searches the line table for the start and the end
// point of a query with one shared end-of-line compare.
// ---------------------------------------------------------------------------
module tlt_search #(
    parameter int MAX_LINES   = 1024,
    parameter int OFFSET_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [23:0]                    i_query_offset,
    input  logic [23:0]                    i_query_length,
    input  logic [$clog2(MAX_LINES+1)-1:0] i_line_count,
    input  logic                           i_take,
    output logic                           o_busy,
    output logic                           o_done,
    output tlt_pkg::t_out_word             o_answer,
    output logic                           o_rd_en,
    output logic [$clog2(MAX_LINES)-1:0]   o_rd_addr,
    input  logic [2*OFFSET_BITS-1:0]       i_rd_data
);
    import tlt_pkg::*;

    localparam int OB  = OFFSET_BITS;
    localparam int LCW = $clog2(MAX_LINES+1);
    localparam int AW  = $clog2(MAX_LINES);
    localparam int PW  = (OB + 1 > 25) ? OB + 1 : 25;
    localparam int XW  = LCW + 10;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_CMP   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state         r_state, n_state;
    logic [LCW-1:0] r_lo, n_lo;
    logic [LCW-1:0] r_hi, n_hi;
    logic [LCW-1:0] r_mid, n_mid;
    logic [PW-1:0]  r_point, n_point;
    logic [PW-1:0]  r_end_pt, n_end_pt;
    logic [OB-1:0]  r_cand, n_cand;
    logic           r_second, n_second;
    logic           r_past, n_past;
    logic [9:0]     r_start_line, n_start_line;
    logic [23:0]    r_start_col, n_start_col;
    logic [9:0]     r_end_line, n_end_line;
    logic [23:0]    r_end_col, n_end_col;

    logic [LCW-1:0] w_mid;
    logic [OB-1:0]  w_tab_off;
    logic [OB-1:0]  w_tab_len;
    logic [PW-1:0]  w_stored_end;
    logic           w_pt_past;
    logic [LCW-1:0] w_sel;
    logic [XW-1:0]  w_sel_ext;
    logic [9:0]     w_line;
    logic [PW-1:0]  w_cand_pt;
    logic [PW-1:0]  w_diff;
    logic [23:0]    w_col;

    // shared datapath: midpoint, stored line end, finishing a point
    always_comb begin
        w_mid        = r_lo + ((r_hi - r_lo) >> 1);
        w_tab_off    = i_rd_data[2*OB-1:OB];
        w_tab_len    = i_rd_data[OB-1:0];
        w_stored_end = PW'(w_tab_off) + PW'(w_tab_len);

        w_pt_past = (r_lo >= i_line_count);
        w_sel     = w_pt_past ? i_line_count : r_lo;
        w_sel_ext = {10'd0, w_sel};
        w_line    = (w_sel_ext > XW'(LINE_MAX)) ? LINE_MAX : w_sel_ext[9:0];

        w_cand_pt = PW'(r_cand);
        w_diff    = r_point - w_cand_pt;
        if (w_pt_past || (r_point < w_cand_pt)) begin
            w_col = '0;
        end else if (w_diff > PW'(COL_MAX)) begin
            w_col = COL_MAX;
        end else begin
            w_col = w_diff[23:0];
        end
    end

    // search sequencer
    always_comb begin
        n_state      = r_state;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_point      = r_point;
        n_end_pt     = r_end_pt;
        n_cand       = r_cand;
        n_second     = r_second;
        n_past       = r_past;
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        n_end_line   = r_end_line;
        n_end_col    = r_end_col;
        o_rd_en      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_point  = PW'(i_query_offset);
                    n_end_pt = PW'(i_query_offset) + PW'(i_query_length);
                    n_lo     = '0;
                    n_hi     = i_line_count;
                    n_second = 1'b0;
                    n_past   = 1'b0;
                    n_state  = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_lo < r_hi) begin
                    o_rd_en = 1'b1;
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end else begin
                    // point finished
                    n_past = r_past | w_pt_past;
                    if (r_second) begin
                        n_end_line = w_line;
                        n_end_col  = w_col;
                        n_state    = S_DONE;
                    end else begin
                        n_start_line = w_line;
                        n_start_col  = w_col;
                        n_point      = r_end_pt;
                        n_lo         = '0;
                        n_hi         = i_line_count;
                        n_second     = 1'b1;
                    end
                end
            end
            S_CMP: begin
                if (w_stored_end <= r_point) begin
                    n_lo = r_mid + LCW'(1);
                end else begin
                    n_hi   = r_mid;
                    n_cand = w_tab_off;
                end
                n_state = S_ISSUE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr = w_mid[AW-1:0];
    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = (r_state == S_DONE);

    // answer word
    always_comb begin
        o_answer              = '0;
        o_answer.result_kind  = RK_QUERY;
        o_answer.status       = r_past ? ST_PAST : ST_OK;
        o_answer.start_line   = r_start_line;
        o_answer.start_column = r_start_col;
        o_answer.end_line     = r_end_line;
        o_answer.end_column   = r_end_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
            r_past   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_past   <= n_past;
        end
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_point      <= n_point;
        r_end_pt     <= n_end_pt;
        r_cand       <= n_cand;
        r_start_line <= n_start_line;
        r_start_col  <= n_start_col;
        r_end_line   <= n_end_line;
        r_end_col    <= n_end_col;
    end

    // a compare step always works on a non-empty interval
    a_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_lo < r_hi && r_mid >= r_lo && r_mid < r_hi))
        else $error("search step outside interval");

    // a finished answer waits until it is taken
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_take) |=> (r_state == S_DONE))
        else $error("answer dropped before take");
endmodule

// ===== design/text_line_table_and_offset_lookup.sv =====
// ---------------------------------------------------------------------------
// text_line_table_and_offset_lookup - line table and offset lookup
// Splits a byte stream into lines, emits line records, stores each line in a
// table while it has room, and answers offset-to-line/column queries by binary search.
//
//   channel  dir  handshake                  word
//   in       in   i_in_valid / o_in_stall    t_in_word
//   out      out  o_out_valid / i_out_stall  t_out_word
//
// Text byte and end items are accepted whenever the input is not stalled, so
// text streams at one byte a cycle while the output register drains. A query
// runs a binary search; each step issues a read through the single registered
// read port of the line table and then compares, and the input is stalled
// meanwhile. Reset is synchronous; the table needs no clearing pass.
// A stalled output holds its word and stalls the input for as long as the
// occupied output register is held.
// ---------------------------------------------------------------------------
module text_line_table_and_offset_lookup #(
    parameter int MAX_LINES   = 1024,
    parameter int OFFSET_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tlt_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tlt_pkg::t_out_word o_out_word
);
    import tlt_pkg::*;

    localparam int LCW = $clog2(MAX_LINES+1);
    localparam int AW  = $clog2(MAX_LINES);
    localparam int DW  = 2 * OFFSET_BITS;

    logic      r_out_valid, n_out_valid;
    t_out_word r_out_word, n_out_word;

    logic           w_accept;
    logic           w_out_free;
    logic           w_busy;
    logic           w_done;
    logic           w_take;
    logic           w_query;
    t_scan_cmd      w_cmd;
    logic           w_rec_valid;
    t_out_word      w_rec;
    t_out_word      w_answer;
    logic [LCW-1:0] w_line_count;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    logic [DW-1:0]  w_wr_data;
    logic           w_rd_en;
    logic [AW-1:0]  w_rd_addr;
    logic [DW-1:0]  w_rd_data;

    // input handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = w_busy || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_take     = w_done && w_out_free;

    // decode of accepted words
    always_comb begin
        w_cmd            = '0;
        w_cmd.byte_value = i_in_word.byte_value;
        w_query          = 1'b0;
        case (i_in_word.kind)
            KIND_TEXT:  w_cmd.text = w_accept;
            KIND_END:   w_cmd.eot  = w_accept;
            KIND_QUERY: w_query    = w_accept;
            default:    ;
        endcase
    end

    tlt_scan #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_rec_valid  (w_rec_valid),
        .o_rec        (w_rec),
        .o_line_count (w_line_count),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data)
    );

    tlt_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_LINES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    tlt_search #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_query),
        .i_query_offset (i_in_word.query_offset),
        .i_query_length (i_in_word.query_length),
        .i_line_count   (w_line_count),
        .i_take         (w_take),
        .o_busy         (w_busy),
        .o_done         (w_done),
        .o_answer       (w_answer),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data)
    );

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_take) begin
            n_out_valid = 1'b1;
            n_out_word  = w_answer;
        end else if (w_rec_valid) begin
            n_out_valid = 1'b1;
            n_out_word  = w_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // an accepted query starts the search
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> w_busy)
        else $error("query accepted without search");

    // the scanner stays quiet while a search runs
    a_no_rec_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_rec_valid)
        else $error("line record during search");

    // a query answer only appears after the search has finished
    a_answer_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_out_word.result_kind == RK_QUERY) |-> $past(w_done))
        else $error("answer without finished search");
endmodule
